[rtl/core/rfcp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfcp_pkg: shared types and constants of the rpm tachometer core
// widths of fields and registers, register indexes and reset values, divider handshake types
// ----------------------------------------------------------------------------
package rfcp_pkg;

   // capture timer width
   localparam int CAPTURE_BITS = 16;

   // register field widths
   localparam int HZ_W  = 26;
   localparam int RPM_W = 16;
   localparam int PPR_W = 5;
   localparam int TMO_W = 16;
   localparam int MS_W  = 32;

   // divider widths: timer_hz * 60 fits in hz width + 6 bits
   localparam int NUM_W = HZ_W + 6;
   localparam int DEN_W = ((CAPTURE_BITS > RPM_W) ? CAPTURE_BITS : RPM_W) + PPR_W;
   localparam int CNT_W = $clog2(NUM_W);
   localparam int THR_W = NUM_W + PPR_W;

   // stream and csr port widths
   localparam int REQ_DATA_W = ((CAPTURE_BITS + MS_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = RPM_W;
   localparam int RSP_USER_W = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = HZ_W;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_TIMER_HZ     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_RPM      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PPR          = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_STOP_TIMEOUT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ALT_MODE     = 3'd4;

   // register reset values
   localparam logic [HZ_W-1:0]  RST_TIMER_HZ     = 26'd1000000;
   localparam logic [RPM_W-1:0] RST_MAX_RPM      = 16'd20000;
   localparam logic [PPR_W-1:0] RST_PPR          = 5'd1;
   localparam logic [TMO_W-1:0] RST_STOP_TIMEOUT = 16'd1000;

   // item kinds
   localparam logic REQ_CAPTURE = 1'b0;
   localparam logic REQ_TICK    = 1'b1;

   localparam logic [RPM_W-1:0] RPM_SAT = '1;

   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] numer;
      logic [DEN_W-1:0] denom;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [NUM_W-1:0] quot;
   } div_rsp_type;

endpackage

[rtl/core/rfcp_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfcp_div: bit-serial restoring divider
// one quotient bit per cycle, numerator shifted out msb first
// ----------------------------------------------------------------------------
module rfcp_div
   import rfcp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [NUM_W-1:0] quo_ff, quo_in;

   logic [DEN_W:0] trial;
   logic [DEN_W:0] diff;
   logic           fits;

   // shifted partial remainder against divisor
   assign trial = {rem_ff, quo_ff[NUM_W-1]};
   assign fits  = (trial >= {1'b0, den_ff});
   assign diff  = trial - {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NUM_W - 1);
         rem_in  = '0;
         den_in  = div_req.denom;
         quo_in  = div_req.numer;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         quo_in = {quo_ff[NUM_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quo_ff;

endmodule

[rtl/core/rpm_from_capture_period_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpm_from_capture_period_core: engine tachometer by period measurement
// capture beats give the period between timer captures, the rpm follows from
// timer_hz*60/(period*pulses_per_rev); tick beats force rpm to zero on timeout
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake              payload
//  req      in         req_tvalid/req_tready  tdata: capture_value, now_ms
//                                             tuser: req_type
//  rsp      out        rsp_tvalid/rsp_tready  tdata: rpm
//                                             tuser: measured, stopped
//  csr      in         csr_valid/csr_ready    csr_index, csr_data
//
//  one beat in flight; tick, skipped capture or capture with nothing to divide goes
//  from decode straight to output, a capture rejected as noise runs the divider once,
//  a measured capture runs the bit-serial divider twice before output
//  reset: synchronous, restores register defaults and clears the history
//  stalls: a new req beat is taken while the previous rsp beat still waits;
//  the core then holds its result until the rsp register frees up
// ----------------------------------------------------------------------------
module rpm_from_capture_period_core
   import rfcp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // capture_value, now_ms
   input  logic                  req_tuser,   // req_type

   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // rpm
   output logic [RSP_USER_W-1:0] rsp_tuser,   // measured, stopped

   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_DECODE = 7'b0000010,
      S_DIV1   = 7'b0000100,
      S_MUL    = 7'b0001000,
      S_CHECK  = 7'b0010000,
      S_DIV2   = 7'b0100000,
      S_OUT    = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [HZ_W-1:0]  timer_hz_ff;
   logic [RPM_W-1:0] max_rpm_ff;
   logic [PPR_W-1:0] ppr_ff;
   logic [TMO_W-1:0] timeout_ff;
   logic             alt_ff;

   // latched beat
   logic                    type_ff, type_in;
   logic [CAPTURE_BITS-1:0] cap_ff, cap_in;
   logic [MS_W-1:0]         now_ff, now_in;

   // tachometer history
   logic [CAPTURE_BITS-1:0] last_count_ff, last_count_in;
   logic                    have_last_ff, have_last_in;
   logic [RPM_W-1:0]        speed_ff, speed_in;
   logic [MS_W-1:0]         last_seen_ff, last_seen_in;
   logic                    skip_ff, skip_in;

   // working values of one capture
   logic [CAPTURE_BITS-1:0] ticks_ff, ticks_in;
   logic [NUM_W-1:0]        min_ticks_ff, min_ticks_in;
   logic [THR_W-1:0]        thr_ff, thr_in;
   logic [DEN_W-1:0]        den2_ff, den2_in;
   logic                    meas_ff, meas_in;
   logic                    stop_ff, stop_in;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [RSP_USER_W-1:0] rsp_user_ff, rsp_user_in;

   div_req_type      div_req;
   div_rsp_type      div_rsp;
   logic [NUM_W-1:0] numer;
   logic [DEN_W-1:0] den1;
   logic [MS_W-1:0]  elapsed;
   logic             run;

   rfcp_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // timer_hz * 60 as (hz << 6) - (hz << 2)
   assign numer   = {timer_hz_ff, 6'b0} - {4'b0, timer_hz_ff, 2'b0};
   assign den1    = DEN_W'(max_rpm_ff) * DEN_W'(ppr_ff);
   assign elapsed = now_ff - last_seen_ff;

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   always_comb begin
      state_in      = state_ff;
      type_in       = type_ff;
      cap_in        = cap_ff;
      now_in        = now_ff;
      last_count_in = last_count_ff;
      have_last_in  = have_last_ff;
      speed_in      = speed_ff;
      last_seen_in  = last_seen_ff;
      skip_in       = skip_ff;
      ticks_in      = ticks_ff;
      min_ticks_in  = min_ticks_ff;
      thr_in        = thr_ff;
      den2_in       = den2_ff;
      meas_in       = meas_ff;
      stop_in       = stop_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_user_in   = rsp_user_ff;
      run           = 1'b1;
      div_req.start = 1'b0;
      div_req.numer = numer;
      div_req.denom = den1;

      // rsp beat taken downstream
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               type_in  = req_tuser;
               cap_in   = req_tdata[CAPTURE_BITS-1:0];
               now_in   = req_tdata[CAPTURE_BITS +: MS_W];
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            meas_in  = 1'b0;
            stop_in  = 1'b0;
            state_in = S_OUT;
            if (type_ff == REQ_TICK) begin
               // timeout since last processed capture
               if (elapsed >= MS_W'(timeout_ff)) begin
                  speed_in     = '0;
                  have_last_in = 1'b0;
                  stop_in      = 1'b1;
               end
            end else begin
               // alternate mode: toggle flips, capture runs when it lands on zero
               if (alt_ff) begin
                  skip_in = ~skip_ff;
                  run     = skip_ff;
               end
               if (run) begin
                  last_seen_in  = now_ff;
                  last_count_in = cap_ff;
                  have_last_in  = 1'b1;
                  ticks_in      = cap_ff - last_count_ff;
                  if (have_last_ff && (max_rpm_ff != '0) && (ppr_ff != '0)) begin
                     // noise limit: numer / (max_rpm * ppr)
                     div_req.start = 1'b1;
                     state_in      = S_DIV1;
                  end
               end
            end
         end
         S_DIV1: begin
            if (div_rsp.done) begin
               min_ticks_in = div_rsp.quot;
               state_in     = S_MUL;
            end
         end
         S_MUL: begin
            thr_in   = THR_W'(min_ticks_ff) * THR_W'(ppr_ff);
            den2_in  = DEN_W'(ticks_ff) * DEN_W'(ppr_ff);
            state_in = S_CHECK;
         end
         S_CHECK: begin
            // zero period or a period below min_ticks * ppr is noise
            if ((ticks_ff != '0) && (THR_W'(ticks_ff) >= thr_ff)) begin
               div_req.start = 1'b1;
               div_req.denom = den2_ff;
               state_in      = S_DIV2;
            end else begin
               state_in = S_OUT;
            end
         end
         S_DIV2: begin
            if (div_rsp.done) begin
               if (div_rsp.quot[NUM_W-1:RPM_W] != '0) begin
                  speed_in = RPM_SAT;
               end else begin
                  speed_in = div_rsp.quot[RPM_W-1:0];
               end
               meas_in  = 1'b1;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            // wait until the result register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = speed_ff;
               rsp_user_in  = {stop_ff, meas_ff};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control and history
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         last_count_ff <= '0;
         have_last_ff  <= 1'b0;
         speed_ff      <= '0;
         last_seen_ff  <= '0;
         skip_ff       <= 1'b1;
         meas_ff       <= 1'b0;
         stop_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         last_count_ff <= last_count_in;
         have_last_ff  <= have_last_in;
         speed_ff      <= speed_in;
         last_seen_ff  <= last_seen_in;
         skip_ff       <= skip_in;
         meas_ff       <= meas_in;
         stop_ff       <= stop_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      type_ff      <= type_in;
      cap_ff       <= cap_in;
      now_ff       <= now_in;
      ticks_ff     <= ticks_in;
      min_ticks_ff <= min_ticks_in;
      thr_ff       <= thr_in;
      den2_ff      <= den2_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_user_ff  <= rsp_user_in;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         timer_hz_ff <= RST_TIMER_HZ;
         max_rpm_ff  <= RST_MAX_RPM;
         ppr_ff      <= RST_PPR;
         timeout_ff  <= RST_STOP_TIMEOUT;
         alt_ff      <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_TIMER_HZ:     timer_hz_ff <= csr_data[HZ_W-1:0];
            REG_MAX_RPM:      max_rpm_ff  <= csr_data[RPM_W-1:0];
            REG_PPR:          ppr_ff      <= csr_data[PPR_W-1:0];
            REG_STOP_TIMEOUT: timeout_ff  <= csr_data[TMO_W-1:0];
            REG_ALT_MODE:     alt_ff      <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

endmodule
